[hdl/ccsc_pkg.sv]
// ----------------------------------------------------------------------------
// ccsc_pkg
// Shared types and constants of the compressor cycle and speed controller.
// ----------------------------------------------------------------------------
package ccsc_pkg;

   // compressor phase, also the value on the rsp_phase port
   typedef enum logic [1:0] {
      PH_LOCKOUT  = 2'd0,
      PH_OFF      = 2'd1,
      PH_STARTING = 2'd2,
      PH_RUN      = 2'd3
   } phase_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_EXEC = 2'd3
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;    // capture request beat, start remote scaling
      logic mul;     // remote power times cap
      logic div;     // scale product down by 100
      logic commit;  // apply tick, update drive outputs
   } cmd_type;

   // power mode codes
   localparam logic [1:0] MODE_ECO    = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_HIGH   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_SETPOINT  = 3'd0;
   localparam logic [2:0] CSR_MODE      = 3'd1;
   localparam logic [2:0] CSR_MIN_SPEED = 3'd2;
   localparam logic [2:0] CSR_MAX_SPEED = 3'd3;
   localparam logic [2:0] CSR_DEF_SPEED = 3'd4;
   localparam logic [2:0] CSR_HYST      = 3'd5;
   localparam logic [2:0] CSR_LIMIT     = 3'd6;
   localparam logic [2:0] CSR_LIMIT_ECO = 3'd7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // x/5 as (x*205)>>10, exact for x below 1024
   localparam logic [7:0] DIV5_MUL   = 8'd205;
   localparam int         DIV5_SHIFT = 10;
   // x/100 as (x*1311)>>17, exact for x below 4699
   localparam logic [10:0] DIV100_MUL   = 11'd1311;
   localparam int          DIV100_SHIFT = 17;

   localparam logic [7:0] PHASE_TIMER_RESET = 8'd20;
   localparam logic [5:0] TREND_PERIOD      = 6'd60;
   localparam logic [5:0] ECO_SPAN          = 6'd3;
   localparam logic [4:0] NORMAL_DERATE     = 5'd2;

   localparam logic signed [11:0] DIFF_BOOST = 12'sd100;
   localparam logic signed [11:0] DIFF_WIDE  = 12'sd40;
   localparam logic signed [11:0] TREND_FAST = -12'sd5;
   localparam logic signed [11:0] TREND_SLOW = -12'sd1;

endpackage

[hdl/ccsc_ctrl.sv]
// ----------------------------------------------------------------------------
// ccsc_ctrl
// Sequencer: takes one request beat, steps the remote scaling, then commits
// the tick once the result register is free.
// ----------------------------------------------------------------------------
module ccsc_ctrl
   import ccsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_busy;

   // result register still holds a beat that is not taken
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (!out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.load   = req_valid;
         ST_MUL:  cmd.mul    = 1'b1;
         ST_DIV:  cmd.div    = 1'b1;
         ST_EXEC: cmd.commit = !out_busy;
         default: cmd = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = cmd.commit || out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/ccsc_dp.sv]
// ----------------------------------------------------------------------------
// ccsc_dp
// Datapath: configuration registers, request capture, remote power scaling,
// phase/timer/speed state and the held drive outputs.
// ----------------------------------------------------------------------------
module ccsc_dp
   import ccsc_pkg::*;
#(
   parameter int LOCKOUT_TICKS      = 120,
   parameter int START_DELAY_TICKS  = 10,
   parameter int MIN_RUN_TICKS      = 60,
   parameter int FAN_SPINDOWN_TICKS = 30,
   parameter int ECO_RESTART_HYST   = 30,
   parameter int HIGH_OVERSHOOT     = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_kind,
   input  logic                  req_enabled,
   input  logic signed [10:0]    req_temperature_tenths,
   input  logic [7:0]            req_measured_power,
   input  logic [6:0]            req_remote_demand,
   input  logic [6:0]            req_remote_limit,
   output logic                  rsp_compressor_on,
   output logic                  rsp_fan_on,
   output logic [4:0]            rsp_speed_index,
   output logic [1:0]            rsp_phase
);

   localparam logic [7:0] LOCK_T  = 8'(LOCKOUT_TICKS);
   localparam logic [7:0] START_T = 8'(START_DELAY_TICKS);
   localparam logic [7:0] RUN_T   = 8'(MIN_RUN_TICKS);
   localparam logic [7:0] FAN_T   = 8'(FAN_SPINDOWN_TICKS);
   localparam logic signed [11:0] ECO_HYST  = 12'(ECO_RESTART_HYST);
   localparam logic signed [11:0] SHUT_HIGH = 12'sd0 - 12'(HIGH_OVERSHOOT);

   // configuration registers
   logic signed [9:0] setpoint_ff;
   logic [1:0]        mode_ff;
   logic [4:0]        min_speed_ff, max_speed_ff, def_speed_ff;
   logic [6:0]        hyst_ff;
   logic [7:0]        limit_ff, limit_eco_ff;

   // captured request
   logic              kind_ff, en_ff, remote_ff;
   logic signed [10:0] temp_ff;
   logic [7:0]        pwr_ff;
   logic [6:0]        rp_ff;
   logic [4:0]        cap_ff;
   logic [11:0]       prod_ff;
   logic [4:0]        remote_speed_ff;

   // controller state
   phase_type         phase_ff, phase_in;
   logic [7:0]        ptimer_ff, ptimer_in, ftimer_ff, ftimer_in;
   logic [4:0]        speed_ff, speed_in;
   logic signed [10:0] prev_ff, prev_in;
   logic [5:0]        count_ff, count_in;
   logic              comp_ff, comp_in, fan_ff, fan_in;
   logic [4:0]        drv_speed_ff, drv_speed_in;

   // shared terms
   logic [1:0]        mode;
   logic signed [11:0] diff;
   logic [14:0]       cap_prod;
   logic [22:0]       quot_prod;
   logic [4:0]        start_speed;
   logic [4:0]        run_speed;
   logic [5:0]        run_count;
   logic signed [10:0] run_prev;

   assign mode = (mode_ff == MODE_ECO || mode_ff == MODE_HIGH) ? mode_ff : MODE_NORMAL;
   assign diff = 12'(temp_ff) - 12'(setpoint_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= 10'sd40;
         mode_ff      <= MODE_NORMAL;
         min_speed_ff <= 5'd1;
         max_speed_ff <= 5'd20;
         def_speed_ff <= 5'd10;
         hyst_ff      <= 7'd20;
         limit_ff     <= 8'd200;
         limit_eco_ff <= 8'd100;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SETPOINT:  setpoint_ff  <= $signed(csr_wdata);
            CSR_MODE:      mode_ff      <= csr_wdata[1:0];
            CSR_MIN_SPEED: min_speed_ff <= csr_wdata[4:0];
            CSR_MAX_SPEED: max_speed_ff <= csr_wdata[4:0];
            CSR_DEF_SPEED: def_speed_ff <= csr_wdata[4:0];
            CSR_HYST:      hyst_ff      <= csr_wdata[6:0];
            CSR_LIMIT:     limit_ff     <= csr_wdata[7:0];
            CSR_LIMIT_ECO: limit_eco_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // remote scaling: cap = limit/5, then remote demand*cap, then /100
   assign cap_prod  = 15'(req_remote_limit) * 15'(DIV5_MUL);
   assign quot_prod = 23'(prod_ff) * 23'(DIV100_MUL);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         en_ff     <= req_enabled;
         temp_ff   <= req_temperature_tenths;
         pwr_ff    <= req_measured_power;
         rp_ff     <= req_remote_demand;
         remote_ff <= (req_remote_demand != 7'd0) && (req_remote_limit != 7'd0);
         cap_ff    <= cap_prod[DIV5_SHIFT +: 5];
      end
      if (cmd.mul) prod_ff <= 12'(rp_ff) * 12'(cap_ff);
      if (cmd.div) remote_speed_ff <= quot_prod[DIV100_SHIFT +: 5];
   end

   // speed while starting
   always_comb begin
      if (remote_ff)                 start_speed = remote_speed_ff;
      else if (setpoint_ff > 10'sd0) start_speed = min_speed_ff;
      else                           start_speed = def_speed_ff;
   end

   // speed while running: mode cap, trend step every period, power derate; remote speed overrides
   always_comb begin
      logic [4:0]        hi, sp0, sp1;
      logic [5:0]        eco_hi, cnt_inc;
      logic [7:0]        thr;
      logic signed [11:0] trend, trend_thr;
      eco_hi    = {1'b0, min_speed_ff} + ECO_SPAN;
      hi        = max_speed_ff;
      sp1       = 5'd0;
      trend_thr = TREND_SLOW;
      case (mode)
         MODE_ECO:    hi = eco_hi[5] ? 5'd31 : eco_hi[4:0];
         MODE_NORMAL: begin
            if (max_speed_ff > NORMAL_DERATE) hi = max_speed_ff - NORMAL_DERATE;
         end
         default: hi = max_speed_ff;
      endcase
      sp0     = (speed_ff > hi) ? hi : speed_ff;
      thr     = (mode == MODE_ECO) ? limit_eco_ff : limit_ff;
      cnt_inc = count_ff + 6'd1;
      trend   = 12'(temp_ff) - 12'(prev_ff);
      sp1       = sp0;
      run_count = cnt_inc;
      run_prev  = prev_ff;
      if (cnt_inc == TREND_PERIOD) begin
         run_count = 6'd0;
         run_prev  = temp_ff;
         trend_thr = (diff > DIFF_WIDE) ? TREND_FAST : TREND_SLOW;
         if (mode == MODE_HIGH) begin
            sp1 = hi;
         end else if (diff > DIFF_BOOST && pwr_ff < thr) begin
            sp1 = hi;
         end else if (trend > trend_thr && sp0 < hi) begin
            sp1 = sp0 + 5'd1;
         end else if (trend < trend_thr && sp0 > min_speed_ff) begin
            sp1 = sp0 - 5'd1;
         end
      end
      if (mode != MODE_HIGH && sp1 > min_speed_ff && pwr_ff > thr) sp1 = sp1 - 5'd1;
      run_speed = sp1;
      if (remote_ff) begin
         run_speed = remote_speed_ff;
         run_count = count_ff;
         run_prev  = prev_ff;
      end
   end

   // tick / forced lockout next state
   always_comb begin
      logic [7:0]      pt1, ft1;
      phase_type       ph1;
      logic signed [11:0] restart_thr;
      pt1          = ptimer_ff;
      ft1          = ftimer_ff;
      ph1          = phase_ff;
      restart_thr  = (mode == MODE_ECO) ? ECO_HYST : 12'(hyst_ff);
      phase_in     = phase_ff;
      ptimer_in    = ptimer_ff;
      ftimer_in    = ftimer_ff;
      speed_in     = speed_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      comp_in      = comp_ff;
      fan_in       = fan_ff;
      drv_speed_in = drv_speed_ff;
      if (kind_ff) begin
         comp_in      = 1'b0;
         fan_in       = 1'b0;
         drv_speed_in = 5'd0;
         ptimer_in    = LOCK_T;
         phase_in     = PH_LOCKOUT;
      end else if (en_ff) begin
         if (ptimer_ff != 8'd0) begin
            pt1 = ptimer_ff - 8'd1;
            if (pt1 == 8'd0 && phase_ff != PH_RUN) ph1 = phase_type'(phase_ff + 2'd1);
         end
         if (ftimer_ff != 8'd0) ft1 = ftimer_ff - 8'd1;
         phase_in  = ph1;
         ptimer_in = pt1;
         ftimer_in = ft1;
         case (ph1)
            PH_LOCKOUT: begin
               comp_in      = 1'b0;
               fan_in       = (ft1 != 8'd0);
               drv_speed_in = 5'd0;
            end
            PH_OFF: begin
               comp_in      = 1'b0;
               fan_in       = (ft1 != 8'd0);
               drv_speed_in = 5'd0;
               if (diff >= restart_thr && pt1 == 8'd0) begin
                  ptimer_in = START_T;
                  ftimer_in = START_T;
                  fan_in    = (START_T != 8'd0);
               end
            end
            PH_STARTING: begin
               speed_in     = start_speed;
               comp_in      = 1'b1;
               fan_in       = 1'b1;
               drv_speed_in = start_speed;
               if (pt1 == 8'd0) begin
                  count_in  = 6'd0;
                  prev_in   = temp_ff;
                  ptimer_in = RUN_T;
               end
            end
            PH_RUN: begin
               speed_in = run_speed;
               count_in = run_count;
               prev_in  = run_prev;
               if (mode == MODE_HIGH && diff <= 12'sd0 && diff > SHUT_HIGH) begin
                  // near setpoint in high mode: hold at minimum speed
                  if (run_speed > min_speed_ff) speed_in = min_speed_ff;
                  comp_in      = 1'b1;
                  fan_in       = 1'b1;
                  drv_speed_in = (run_speed > min_speed_ff) ? min_speed_ff : run_speed;
               end else if (diff <= ((mode == MODE_HIGH) ? SHUT_HIGH : 12'sd0)) begin
                  // shutdown: drive outputs keep their value this tick
                  phase_in  = PH_LOCKOUT;
                  ptimer_in = LOCK_T;
                  ftimer_in = FAN_T;
               end else begin
                  comp_in      = 1'b1;
                  fan_in       = 1'b1;
                  drv_speed_in = run_speed;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LOCKOUT;
         ptimer_ff    <= PHASE_TIMER_RESET;
         ftimer_ff    <= 8'd0;
         speed_ff     <= 5'd0;
         prev_ff      <= 11'sd0;
         count_ff     <= 6'd0;
         comp_ff      <= 1'b0;
         fan_ff       <= 1'b0;
         drv_speed_ff <= 5'd0;
      end else if (cmd.commit) begin
         phase_ff     <= phase_in;
         ptimer_ff    <= ptimer_in;
         ftimer_ff    <= ftimer_in;
         speed_ff     <= speed_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         comp_ff      <= comp_in;
         fan_ff       <= fan_in;
         drv_speed_ff <= drv_speed_in;
      end
   end

   // held drive state is the result register
   assign rsp_compressor_on = comp_ff;
   assign rsp_fan_on        = fan_ff;
   assign rsp_speed_index   = drv_speed_ff;
   assign rsp_phase         = phase_ff;

endmodule

[hdl/compressor_cycle_speed_controller.sv]
// ----------------------------------------------------------------------------
// compressor_cycle_speed_controller
// Once-per-second compressor phase, fan and speed controller.
// ----------------------------------------------------------------------------
// The result beat becomes valid once the sequencer has stepped the remote power
// scaling (capture, multiply, scale by 100) and committed the tick; no new
// request beat is taken meanwhile, and req_stall stays high until then.
// A stalled result holds the commit step until the result beat is taken.
// Reset (synchronous, active high): phase lockout, phase timer 20, all other controller
// state and drive outputs zero, registers at their documented defaults.
module compressor_cycle_speed_controller
   import ccsc_pkg::*;
#(
   parameter int LOCKOUT_TICKS      = 120,
   parameter int START_DELAY_TICKS  = 10,
   parameter int MIN_RUN_TICKS      = 60,
   parameter int FAN_SPINDOWN_TICKS = 30,
   parameter int ECO_RESTART_HYST   = 30,
   parameter int HIGH_OVERSHOOT     = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic                  req_enabled,
   input  logic signed [10:0]    req_temperature_tenths,
   input  logic [7:0]            req_measured_power,
   input  logic [6:0]            req_remote_demand,
   input  logic [6:0]            req_remote_limit,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_compressor_on,
   output logic                  rsp_fan_on,
   output logic [4:0]            rsp_speed_index,
   output logic [1:0]            rsp_phase
);

   cmd_type cmd;

   // sequencer
   ccsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath
   ccsc_dp #(
      .LOCKOUT_TICKS      (LOCKOUT_TICKS),
      .START_DELAY_TICKS  (START_DELAY_TICKS),
      .MIN_RUN_TICKS      (MIN_RUN_TICKS),
      .FAN_SPINDOWN_TICKS (FAN_SPINDOWN_TICKS),
      .ECO_RESTART_HYST   (ECO_RESTART_HYST),
      .HIGH_OVERSHOOT     (HIGH_OVERSHOOT)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_kind               (req_kind),
      .req_enabled            (req_enabled),
      .req_temperature_tenths (req_temperature_tenths),
      .req_measured_power     (req_measured_power),
      .req_remote_demand      (req_remote_demand),
      .req_remote_limit       (req_remote_limit),
      .rsp_compressor_on      (rsp_compressor_on),
      .rsp_fan_on             (rsp_fan_on),
      .rsp_speed_index        (rsp_speed_index),
      .rsp_phase              (rsp_phase)
   );

endmodule

[hdl/ccsc_checker.sv]
// ----------------------------------------------------------------------------
// ccsc_checker
// Port-level checks of the compressor controller, bound to the top level.
// ----------------------------------------------------------------------------
module ccsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_compressor_on,
   input logic       rsp_fan_on,
   input logic [4:0] rsp_speed_index,
   input logic [1:0] rsp_phase
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one request at a time: busy after each accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous beat in work");

   // drive off always carries speed zero
   a_off_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compressor_on || rsp_speed_index == 5'd0))
      else $error("speed nonzero with compressor off");

   // compressor never runs without the condenser fan
   a_comp_needs_fan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_compressor_on || rsp_fan_on))
      else $error("compressor on with fan off");

   // stalled result beat holds its phase, speed and compressor state
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_phase)
         && $stable(rsp_speed_index) && $stable(rsp_compressor_on)))
      else $error("stalled result beat changed");

endmodule

bind compressor_cycle_speed_controller ccsc_checker u_ccsc_checker (.*);
